// File: design/agd_pkg.sv
`default_nettype none
package agd_pkg;

  localparam int TIME_W    = 32;
  localparam int ACC_W     = 16;
  localparam int MAG_W     = ACC_W + 1;
  localparam int SQ_W      = 2 * ACC_W - 1;
  localparam int M2_W      = SQ_W + 1;
  localparam int TH_W      = 2 * ACC_W;
  localparam int CFG_W     = 16;
  localparam int FLAT_W    = 15;
  localparam int HITS_W    = 8;
  localparam int QDEPTH    = 4;
  localparam int Q_PTR_W   = $clog2(QDEPTH);
  localparam int Q_CNT_W   = $clog2(QDEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int O_PTR_W   = $clog2(OUT_DEPTH);
  localparam int O_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [HITS_W-1:0] HITS_MAX    = '1;
  localparam logic [ACC_W-1:0]  BASELINE_RST = 16'sd4096;

  typedef enum logic [1:0] {
    GEST_DOWN  = 2'd0,
    GEST_UP    = 2'd1,
    GEST_SHAKE = 2'd2
  } gesture_t;

  typedef enum logic [2:0] {
    REG_REST_LO    = 3'd0,
    REG_REST_HI    = 3'd1,
    REG_FLAT_MIN   = 3'd2,
    REG_SHAKE_HI   = 3'd3,
    REG_SHAKE_LO   = 3'd4,
    REG_HITS       = 3'd5,
    REG_WINDOW     = 3'd6,
    REG_HOLDOFF    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]       rest_mag_low;
    logic [15:0]       rest_mag_high;
    logic [FLAT_W-1:0] flat_min;
    logic [15:0]       shake_mag_high;
    logic [15:0]       shake_mag_low;
    logic [HITS_W-1:0] shake_hits_needed;
    logic [15:0]       shake_window_ms;
    logic [15:0]       event_holdoff_ms;
  } cfg_t;

  // Classified sample handed from the front end to the back end
  typedef struct packed {
    logic signed [ACC_W-1:0] z;
    logic [TIME_W-1:0]       now;
    logic                    rest;
    logic                    peak;
    logic                    flip_cand;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage
`default_nettype wire

// File: design/accel_gesture_detector_unit.sv
// Path: an accepted item is registered in the front-end stage, then in the queue, and its result in the result queue.
// Throughput: one item per cycle while full is low; the back end updates all detector state as it takes an item.
// A four-entry queue between front and back and a two-entry result queue absorb stalls.
// Reset (rst, synchronous): queues empty, registers at defaults, baseline unset,
// peak count, window start and last event time cleared.
`default_nettype none
module accel_gesture_detector_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic signed [15:0]    accel_z,
  input  logic [31:0]           time_ms,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            gesture,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  agd_pkg::cfg_idx_t     cfg_index,
  input  logic [15:0]           cfg_data
);
  import agd_pkg::*;

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t q_wdata, q_head;
  logic     q_push, q_pop;

  // Registers are always writable; the user writes them only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_mag_low      <= 16'd2867;
      cfg.rest_mag_high     <= 16'd5325;
      cfg.flat_min          <= 15'd2457;
      cfg.shake_mag_high    <= 16'd7782;
      cfg.shake_mag_low     <= 16'd410;
      cfg.shake_hits_needed <= 8'd3;
      cfg.shake_window_ms   <= 16'd1500;
      cfg.event_holdoff_ms  <= 16'd2000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REST_LO:  begin cfg.rest_mag_low      <= cfg_data; end
        REG_REST_HI:  begin cfg.rest_mag_high     <= cfg_data; end
        REG_FLAT_MIN: begin cfg.flat_min          <= cfg_data[FLAT_W-1:0]; end
        REG_SHAKE_HI: begin cfg.shake_mag_high    <= cfg_data; end
        REG_SHAKE_LO: begin cfg.shake_mag_low     <= cfg_data; end
        REG_HITS:     begin cfg.shake_hits_needed <= cfg_data[HITS_W-1:0]; end
        REG_WINDOW:   begin cfg.shake_window_ms   <= cfg_data; end
        REG_HOLDOFF:  begin cfg.event_holdoff_ms  <= cfg_data; end
        default:      begin cfg.rest_mag_low      <= cfg.rest_mag_low; end
      endcase
    end
  end

  // Front end: magnitudes, squares, flip candidate and band classification of each item
  agd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .time_ms (time_ms),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // Decoupling queue of classified items
  agd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  // Back end: baseline, flip, shake counting, holdoff and result queue
  agd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .gesture (gesture)
  );

endmodule
`default_nettype wire

// File: design/agd_front.sv
`default_nettype none
module agd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [15:0]             accel_x,
  input  logic signed [15:0]             accel_y,
  input  logic signed [15:0]             accel_z,
  input  logic [31:0]                    time_ms,
  input  agd_pkg::cfg_t                  cfg,
  input  agd_pkg::q_stat_t               q_stat,
  output logic                           q_push,
  output agd_pkg::q_entry_t              q_data
);
  import agd_pkg::*;

  logic                    f1_valid;
  logic [SQ_W-1:0]         f1_sq_x, f1_sq_y, f1_sq_z;
  logic signed [ACC_W-1:0] f1_z;
  logic [TIME_W-1:0]       f1_time;
  logic                    f1_flip_cand;

  logic [TH_W-1:0] th_rest_lo, th_rest_hi, th_shake_hi, th_shake_lo;

  logic [MAG_W-1:0]   ax, ay, az;
  logic [2*MAG_W-1:0] px, py, pz;
  logic [M2_W-1:0]    m2;
  logic               load;

  // Magnitudes of the signed axes, one bit wider to hold full scale
  assign ax = accel_x[ACC_W-1] ? (MAG_W'(0) - {accel_x[ACC_W-1], accel_x}) : {1'b0, accel_x};
  assign ay = accel_y[ACC_W-1] ? (MAG_W'(0) - {accel_y[ACC_W-1], accel_y}) : {1'b0, accel_y};
  assign az = accel_z[ACC_W-1] ? (MAG_W'(0) - {accel_z[ACC_W-1], accel_z}) : {1'b0, accel_z};

  assign px = (2*MAG_W)'(ax) * (2*MAG_W)'(ax);
  assign py = (2*MAG_W)'(ay) * (2*MAG_W)'(ay);
  assign pz = (2*MAG_W)'(az) * (2*MAG_W)'(az);

  assign full   = f1_valid & q_stat.full;
  assign load   = push & ~full;
  assign q_push = f1_valid & ~q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (load) begin
      f1_valid <= 1'b1;
    end else if (q_push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f1_sq_x      <= px[SQ_W-1:0];
      f1_sq_y      <= py[SQ_W-1:0];
      f1_sq_z      <= pz[SQ_W-1:0];
      f1_z         <= accel_z;
      f1_time      <= time_ms[TIME_W-1:0];
      f1_flip_cand <= (az > MAG_W'(cfg.flat_min)) && (az > ax) && (az > ay);
    end
  end

  // Squared band limits, refreshed from configuration every cycle
  always_ff @(posedge clk) begin
    th_rest_lo  <= TH_W'(cfg.rest_mag_low)   * TH_W'(cfg.rest_mag_low);
    th_rest_hi  <= TH_W'(cfg.rest_mag_high)  * TH_W'(cfg.rest_mag_high);
    th_shake_hi <= TH_W'(cfg.shake_mag_high) * TH_W'(cfg.shake_mag_high);
    th_shake_lo <= TH_W'(cfg.shake_mag_low)  * TH_W'(cfg.shake_mag_low);
  end

  assign m2 = M2_W'(f1_sq_x) + M2_W'(f1_sq_y) + M2_W'(f1_sq_z);

  always_comb begin
    q_data.z         = f1_z;
    q_data.now       = f1_time;
    q_data.rest      = (m2 > M2_W'(th_rest_lo)) && (m2 < M2_W'(th_rest_hi));
    q_data.peak      = (m2 > M2_W'(th_shake_hi)) || (m2 < M2_W'(th_shake_lo));
    q_data.flip_cand = f1_flip_cand;
  end

endmodule
`default_nettype wire

// File: design/agd_queue.sv
`default_nettype none
module agd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  agd_pkg::q_entry_t wdata,
  input  logic              pop,
  output agd_pkg::q_entry_t head,
  output agd_pkg::q_stat_t  stat
);
  import agd_pkg::*;

  q_entry_t           mem [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push, do_pop;

  assign stat.full  = (count == Q_CNT_W'(QDEPTH));
  assign stat.valid = (count != '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & stat.valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (stat.full && !do_pop) |=> stat.full)
    else $error("queue lost its fill while stalled");

endmodule
`default_nettype wire

// File: design/agd_back.sv
`default_nettype none
module agd_back (
  input  logic              clk,
  input  logic              rst,
  input  agd_pkg::cfg_t     cfg,
  input  agd_pkg::q_stat_t  q_stat,
  input  agd_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        gesture
);
  import agd_pkg::*;

  logic signed [ACC_W-1:0] baseline_z, baseline_z_next;
  logic                    baseline_valid, baseline_valid_next;
  logic [HITS_W-1:0]       peak_count, peak_count_next;
  logic [TIME_W-1:0]       window_start, window_start_next;
  logic [TIME_W-1:0]       last_event_time, last_event_time_next;

  gesture_t           out_mem [OUT_DEPTH];
  logic [O_PTR_W-1:0] o_wr, o_rd;
  logic [O_CNT_W-1:0] o_count;

  logic              take, opposite, flip, shake, holdoff_ok, res_valid, o_pop;
  logic [TIME_W-1:0] el_last, el_window;
  gesture_t          res_code;

  assign take  = q_stat.valid && (o_count < O_CNT_W'(OUT_DEPTH));
  assign q_pop = take;

  assign el_last    = q_head.now - last_event_time;
  assign el_window  = q_head.now - window_start;
  assign holdoff_ok = el_last > TIME_W'(cfg.event_holdoff_ms);

  always_comb begin
    baseline_z_next      = baseline_z;
    baseline_valid_next  = baseline_valid;
    peak_count_next      = peak_count;
    window_start_next    = window_start;
    last_event_time_next = last_event_time;
    res_code             = GEST_SHAKE;

    if (!baseline_valid && q_head.rest) begin
      baseline_z_next     = q_head.z;
      baseline_valid_next = 1'b1;
    end

    opposite = (q_head.z < 0 && baseline_z_next > 0) || (q_head.z > 0 && baseline_z_next < 0);
    flip     = baseline_valid_next && q_head.flip_cand && opposite && holdoff_ok;
    if (flip) begin
      last_event_time_next = q_head.now;
      res_code             = (q_head.z < 0) ? GEST_DOWN : GEST_UP;
    end

    if (q_head.peak) begin
      if (window_start == '0) begin
        window_start_next = q_head.now;
      end
      if (peak_count != HITS_MAX) begin
        peak_count_next = peak_count + 1'b1;
      end
    end else if (el_window > TIME_W'(cfg.shake_window_ms)) begin
      peak_count_next   = '0;
      window_start_next = '0;
    end

    // A flip in the same sample blocks a shake
    shake = (peak_count_next >= cfg.shake_hits_needed) && holdoff_ok && !flip;
    if (shake) begin
      peak_count_next      = '0;
      window_start_next    = '0;
      last_event_time_next = q_head.now;
      res_code             = GEST_SHAKE;
    end

    res_valid = flip || shake;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_z      <= BASELINE_RST;
      baseline_valid  <= 1'b0;
      peak_count      <= '0;
      window_start    <= '0;
      last_event_time <= '0;
    end else if (take) begin
      baseline_z      <= baseline_z_next;
      baseline_valid  <= baseline_valid_next;
      peak_count      <= peak_count_next;
      window_start    <= window_start_next;
      last_event_time <= last_event_time_next;
    end
  end

  // Result queue
  assign empty   = (o_count == '0);
  assign o_pop   = pop & ~empty;
  assign gesture = out_mem[o_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (take && res_valid) begin
        o_wr <= o_wr + 1'b1;
      end
      if (o_pop) begin
        o_rd <= o_rd + 1'b1;
      end
      if ((take && res_valid) && !o_pop) begin
        o_count <= o_count + 1'b1;
      end else if (o_pop && !(take && res_valid)) begin
        o_count <= o_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_mem[o_wr] <= res_code;
    end
  end

  a_shake_clears: assert property (@(posedge clk) disable iff (rst)
    (take && shake) |=> (peak_count == '0 && window_start == '0))
    else $error("shake did not clear the peak counter");

  a_flip_needs_base: assert property (@(posedge clk) disable iff (rst)
    (take && flip) |=> (baseline_valid && last_event_time == $past(q_head.now)))
    else $error("flip without baseline or event time not taken");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    (o_count == O_CNT_W'(OUT_DEPTH) && !o_pop) |=> !$past(take))
    else $error("item taken while result queue full");

endmodule
`default_nettype wire
